FILE: rtl/core/bmlc_pkg.sv
// shared types, constants and helpers for the button mode light controller
package bmlc_pkg;

  // light mode codes
  localparam logic [1:0] MODE_STROBE  = 2'd0;
  localparam logic [1:0] MODE_FULL    = 2'd1;
  localparam logic [1:0] MODE_REDUCED = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_CMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_MODE   = 3'd4;

  // reset values of the configuration registers
  localparam logic [7:0] SHORT_PRESS_RST = 8'd10;
  localparam logic [7:0] LONG_PRESS_RST  = 8'd90;
  localparam logic [7:0] FULL_CMP_RST    = 8'd50;
  localparam logic [7:0] REDUCED_CMP_RST = 8'd190;
  localparam logic [1:0] WAKE_MODE_RST   = MODE_REDUCED;

  // pwm settings
  localparam logic [10:0] STROBE_TOP    = 11'd1302;
  localparam logic [10:0] DIM_TOP       = 11'd255;
  localparam logic [8:0]  STROBE_DRIVE  = 9'd456;
  localparam logic [8:0]  STROBE_SWITCH = 9'd490;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;

  typedef struct packed {
    logic [7:0] short_press_ticks;
    logic [7:0] long_press_ticks;
    logic [7:0] full_compare;
    logic [7:0] reduced_compare;
    logic [1:0] wake_mode_before;
  } cfg_t;

  typedef struct packed {
    logic        lamp_on;
    logic [1:0]  beam_mode;
    logic [10:0] pwm_top;
    logic [8:0]  drive_compare;
    logic [8:0]  switch_compare;
    logic        kick_watchdog;
  } result_t;

  // mode cycle: reduced -> strobe -> full -> reduced, unused code goes to reduced
  function automatic logic [1:0] next_mode(input logic [1:0] m);
    logic [1:0] n;
    case (m)
      MODE_REDUCED: n = MODE_STROBE;
      MODE_STROBE:  n = MODE_FULL;
      default:      n = MODE_REDUCED;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/bmlc_cfg.sv
// configuration register file
module bmlc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output bmlc_pkg::cfg_t                 cfg
);

  bmlc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_ticks <= bmlc_pkg::SHORT_PRESS_RST;
      cfg_r.long_press_ticks  <= bmlc_pkg::LONG_PRESS_RST;
      cfg_r.full_compare      <= bmlc_pkg::FULL_CMP_RST;
      cfg_r.reduced_compare   <= bmlc_pkg::REDUCED_CMP_RST;
      cfg_r.wake_mode_before  <= bmlc_pkg::WAKE_MODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bmlc_pkg::CFG_SHORT_PRESS: cfg_r.short_press_ticks <= cfg_data;
        bmlc_pkg::CFG_LONG_PRESS:  cfg_r.long_press_ticks  <= cfg_data;
        bmlc_pkg::CFG_FULL_CMP:    cfg_r.full_compare      <= cfg_data;
        bmlc_pkg::CFG_REDUCED_CMP: cfg_r.reduced_compare   <= cfg_data;
        bmlc_pkg::CFG_WAKE_MODE:   cfg_r.wake_mode_before  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/bmlc_step.sv
// lamp state registers and per-tick update logic
module bmlc_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              button_pressed,
  input  logic              enable_pin,
  input  bmlc_pkg::cfg_t    cfg,
  output bmlc_pkg::result_t res
);

  logic       lamp_r, lamp_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic       await_r, await_nxt;
  logic [7:0] ticks_inc;

  // press counter with saturation
  assign ticks_inc = (ticks_r < bmlc_pkg::COUNT_MAX) ? ticks_r + 8'd1 : ticks_r;

  // next state from button and thresholds
  always_comb begin
    lamp_nxt  = lamp_r;
    mode_nxt  = mode_r;
    ticks_nxt = ticks_r;
    await_nxt = await_r;
    if (await_r) begin
      if (!button_pressed) begin
        await_nxt = 1'b0;
        ticks_nxt = 8'd0;
      end
    end else if (button_pressed) begin
      ticks_nxt = ticks_inc;
      if (ticks_inc > cfg.long_press_ticks) begin
        if (lamp_r) begin
          lamp_nxt = 1'b0;
        end else begin
          lamp_nxt = 1'b1;
          mode_nxt = bmlc_pkg::next_mode(cfg.wake_mode_before);
        end
        await_nxt = 1'b1;
        ticks_nxt = 8'd0;
      end
    end else begin
      if (ticks_r > cfg.short_press_ticks && lamp_r) begin
        mode_nxt = bmlc_pkg::next_mode(mode_r);
      end
      ticks_nxt = 8'd0;
    end
  end

  // pwm settings from the updated state
  always_comb begin
    res.lamp_on        = lamp_nxt;
    res.beam_mode      = mode_nxt;
    res.pwm_top        = 11'd0;
    res.drive_compare  = 9'd0;
    res.switch_compare = 9'd0;
    res.kick_watchdog  = button_pressed | enable_pin | ~lamp_nxt;
    if (lamp_nxt) begin
      case (mode_nxt)
        bmlc_pkg::MODE_STROBE: begin
          res.pwm_top        = bmlc_pkg::STROBE_TOP;
          res.drive_compare  = bmlc_pkg::STROBE_DRIVE;
          res.switch_compare = bmlc_pkg::STROBE_SWITCH;
        end
        bmlc_pkg::MODE_FULL: begin
          res.pwm_top       = bmlc_pkg::DIM_TOP;
          res.drive_compare = {1'b0, cfg.full_compare};
        end
        default: begin
          res.pwm_top       = bmlc_pkg::DIM_TOP;
          res.drive_compare = {1'b0, cfg.reduced_compare};
        end
      endcase
    end
  end

  // state registers advance once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_r  <= 1'b0;
      mode_r  <= bmlc_pkg::MODE_REDUCED;
      ticks_r <= 8'd0;
      await_r <= 1'b0;
    end else if (fire) begin
      lamp_r  <= lamp_nxt;
      mode_r  <= mode_nxt;
      ticks_r <= ticks_nxt;
      await_r <= await_nxt;
    end
  end

endmodule

FILE: rtl/core/button_mode_light_controller_top.sv
// button mode light controller: input register, tick update, result register
//
// Usage: one input transfer per 10 ms tick carries the button level and the
// enable pin level. Each tick yields exactly one result transfer with the lamp
// flag, the kept light mode, the PWM period and compare values and the
// watchdog kick for that tick, in input order.
// Configuration: cfg_index selects short press, long press, full compare,
// reduced compare or wake mode (0..4); other indexes are ignored. cfg_ready is
// always high; write only while no tick is in flight.
// Flow: an accepted tick is captured in the input register; when it moves on,
// it is updated against the lamp state and its result is captured in the
// result register together with the new lamp state.
// Throughput: one tick per cycle while out_ready is high; the state update is a
// single short step between the input and result registers.
// Stall: when out_ready is low the result holds, the input register keeps
// its tick, and in_ready drops only once both stages are full.
// Reset: synchronous, clears both stages, lamp off, mode reduced, counter and
// release flag cleared, configuration back to its defaults.
module button_mode_light_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_button_pressed,
  input  logic                           in_enable_pin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_lamp_on,
  output logic [1:0]                     out_beam_mode,
  output logic [10:0]                    out_pwm_top,
  output logic [8:0]                     out_drive_compare,
  output logic [8:0]                     out_switch_compare,
  output logic                           out_kick_watchdog,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  bmlc_pkg::cfg_t    cfg;
  bmlc_pkg::result_t res;
  bmlc_pkg::result_t res_r;

  logic in_valid_r;
  logic btn_r;
  logic ena_r;
  logic out_valid_r;
  logic advance;
  logic fire;

  // pipeline control
  assign advance  = ~out_valid_r | out_ready;
  assign fire     = in_valid_r & advance;
  assign in_ready = ~in_valid_r | advance;

  bmlc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      btn_r <= in_button_pressed;
      ena_r <= in_enable_pin;
    end
  end

  bmlc_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .button_pressed (btn_r),
    .enable_pin     (ena_r),
    .cfg            (cfg),
    .res            (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lamp_on        = res_r.lamp_on;
  assign out_beam_mode      = res_r.beam_mode;
  assign out_pwm_top        = res_r.pwm_top;
  assign out_drive_compare  = res_r.drive_compare;
  assign out_switch_compare = res_r.switch_compare;
  assign out_kick_watchdog  = res_r.kick_watchdog;

endmodule

FILE: rtl/core/bmlc_checker.sv
// port-level checks for the button mode light controller, bound to the top level
module bmlc_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_lamp_on,
  input logic [1:0]  out_beam_mode,
  input logic [10:0] out_pwm_top,
  input logic [8:0]  out_drive_compare,
  input logic [8:0]  out_switch_compare,
  input logic        out_kick_watchdog
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lamp_on) &&
      $stable(out_beam_mode) && $stable(out_pwm_top) && $stable(out_drive_compare) &&
      $stable(out_switch_compare) && $stable(out_kick_watchdog))
    else $error("result changed while stalled");

  // lamp off means all pwm outputs idle and the watchdog kicked
  a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lamp_on |-> out_pwm_top == 11'd0 && out_drive_compare == 9'd0 &&
      out_switch_compare == 9'd0 && out_kick_watchdog)
    else $error("lamp off with active pwm or no watchdog kick");

  // strobe settings
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lamp_on && out_beam_mode == bmlc_pkg::MODE_STROBE |->
      out_pwm_top == bmlc_pkg::STROBE_TOP && out_drive_compare == bmlc_pkg::STROBE_DRIVE &&
      out_switch_compare == bmlc_pkg::STROBE_SWITCH)
    else $error("strobe mode with wrong pwm settings");

  // dimming settings and mode range
  a_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lamp_on && out_beam_mode != bmlc_pkg::MODE_STROBE |->
      out_pwm_top == bmlc_pkg::DIM_TOP && out_switch_compare == 9'd0 &&
      (out_beam_mode == bmlc_pkg::MODE_FULL || out_beam_mode == bmlc_pkg::MODE_REDUCED))
    else $error("dimming mode with wrong pwm settings");

endmodule

bind button_mode_light_controller_top bmlc_port_checks u_bmlc_port_checks (.*);

FILE: verif/bmlc_checker.sv
// result checker for the button mode light controller: predicts each tick and compares
module bmlc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_button_pressed,
  input  logic                           in_enable_pin,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_lamp_on,
  input  logic [1:0]                     out_beam_mode,
  input  logic [10:0]                    out_pwm_top,
  input  logic [8:0]                     out_drive_compare,
  input  logic [8:0]                     out_switch_compare,
  input  logic                           out_kick_watchdog,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_checked,
  output logic                           lamp_lit
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted controller state and register copy
  bmlc_pkg::cfg_t    settings;
  logic [1:0]        cur_mode;
  logic [7:0]        hold_count;
  logic              wait_release;
  bmlc_pkg::result_t tick_results_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
  end

  // mode cycle: reduced -> strobe -> full -> reduced, anything else lands on reduced
  function automatic logic [1:0] following_mode(input logic [1:0] m);
    logic [1:0] n;
    if (m == bmlc_pkg::MODE_REDUCED) n = bmlc_pkg::MODE_STROBE;
    else if (m == bmlc_pkg::MODE_STROBE) n = bmlc_pkg::MODE_FULL;
    else n = bmlc_pkg::MODE_REDUCED;
    return n;
  endfunction

  // one tick of button handling, then the pwm settings for the lamp state
  task automatic predict_tick(input logic pressed, input logic enable,
                              output bmlc_pkg::result_t r);
    r = '0;
    if (wait_release) begin
      if (!pressed) begin
        wait_release = 1'b0;
        hold_count   = '0;
      end
    end else if (pressed) begin
      if (hold_count != bmlc_pkg::COUNT_MAX) hold_count = hold_count + 8'd1;
      if (hold_count > settings.long_press_ticks) begin
        if (lamp_lit) begin
          lamp_lit = 1'b0;
        end else begin
          lamp_lit = 1'b1;
          cur_mode = following_mode(settings.wake_mode_before);
        end
        wait_release = 1'b1;
        hold_count   = '0;
      end
    end else begin
      if (hold_count > settings.short_press_ticks && lamp_lit)
        cur_mode = following_mode(cur_mode);
      hold_count = '0;
    end

    r.lamp_on   = lamp_lit;
    r.beam_mode = cur_mode;
    if (lamp_lit) begin
      case (cur_mode)
        bmlc_pkg::MODE_STROBE: begin
          r.pwm_top        = bmlc_pkg::STROBE_TOP;
          r.drive_compare  = bmlc_pkg::STROBE_DRIVE;
          r.switch_compare = bmlc_pkg::STROBE_SWITCH;
        end
        bmlc_pkg::MODE_FULL: begin
          r.pwm_top       = bmlc_pkg::DIM_TOP;
          r.drive_compare = {1'b0, settings.full_compare};
        end
        default: begin
          r.pwm_top       = bmlc_pkg::DIM_TOP;
          r.drive_compare = {1'b0, settings.reduced_compare};
        end
      endcase
    end
    r.kick_watchdog = pressed | enable | ~lamp_lit;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    bmlc_pkg::result_t want;
    bmlc_pkg::result_t fresh;
    if (!rst_n) begin
      settings.short_press_ticks = bmlc_pkg::SHORT_PRESS_RST;
      settings.long_press_ticks  = bmlc_pkg::LONG_PRESS_RST;
      settings.full_compare      = bmlc_pkg::FULL_CMP_RST;
      settings.reduced_compare   = bmlc_pkg::REDUCED_CMP_RST;
      settings.wake_mode_before  = bmlc_pkg::WAKE_MODE_RST;
      lamp_lit     = 1'b0;
      cur_mode     = bmlc_pkg::MODE_REDUCED;
      hold_count   = '0;
      wait_release = 1'b0;
      tick_results_q.delete();
    end else begin
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bmlc_pkg::CFG_SHORT_PRESS: settings.short_press_ticks = cfg_data;
          bmlc_pkg::CFG_LONG_PRESS:  settings.long_press_ticks  = cfg_data;
          bmlc_pkg::CFG_FULL_CMP:    settings.full_compare      = cfg_data;
          bmlc_pkg::CFG_REDUCED_CMP: settings.reduced_compare   = cfg_data;
          bmlc_pkg::CFG_WAKE_MODE:   settings.wake_mode_before  = cfg_data[1:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("lamp_on", want.lamp_on, out_lamp_on);
          check_field("beam_mode", want.beam_mode, out_beam_mode);
          check_field("pwm_top", want.pwm_top, out_pwm_top);
          check_field("drive_compare", want.drive_compare, out_drive_compare);
          check_field("switch_compare", want.switch_compare, out_switch_compare);
          check_field("kick_watchdog", want.kick_watchdog, out_kick_watchdog);
          results_checked++;
        end
      end
      // tick transfer
      if (in_valid && in_ready) begin
        predict_tick(in_button_pressed, in_enable_pin, fresh);
        tick_results_q.push_back(fresh);
      end
    end
    pending = tick_results_q.size();
  end

endmodule

FILE: verif/button_mode_light_controller_top_tb.sv
// testbench top for the button mode light controller: stimulus, pacing and verdict
module button_mode_light_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_button_pressed = 1'b0;
  logic                           in_enable_pin = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_lamp_on;
  logic [1:0]                     out_beam_mode;
  logic [10:0]                    out_pwm_top;
  logic [8:0]                     out_drive_compare;
  logic [8:0]                     out_switch_compare;
  logic                           out_kick_watchdog;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  int   fail_count;
  int   pending;
  int   results_checked;
  logic lamp_lit;

  int             send_idle_pct = 38;
  int             recv_idle_pct = 84;
  int             tick_count = 0;
  int             setting_count = 0;
  int             cycle_count = 0;
  bmlc_pkg::cfg_t settings;

  button_mode_light_controller_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_button_pressed  (in_button_pressed),
    .in_enable_pin      (in_enable_pin),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lamp_on        (out_lamp_on),
    .out_beam_mode      (out_beam_mode),
    .out_pwm_top        (out_pwm_top),
    .out_drive_compare  (out_drive_compare),
    .out_switch_compare (out_switch_compare),
    .out_kick_watchdog  (out_kick_watchdog),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  bmlc_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_button_pressed  (in_button_pressed),
    .in_enable_pin      (in_enable_pin),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lamp_on        (out_lamp_on),
    .out_beam_mode      (out_beam_mode),
    .out_pwm_top        (out_pwm_top),
    .out_drive_compare  (out_drive_compare),
    .out_switch_compare (out_switch_compare),
    .out_kick_watchdog  (out_kick_watchdog),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_checked    (results_checked),
    .lamp_lit           (lamp_lit)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one tick transfer, with random idle cycles ahead of it; called and returns at a falling edge
  task automatic send_tick(input logic pressed, input logic enable);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_button_pressed <= pressed;
    in_enable_pin     <= enable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_count++;
    @(negedge clk);
  endtask

  // let every outstanding result out
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bmlc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // reprogram all registers once the block has gone quiet
  task automatic apply_settings(input bmlc_pkg::cfg_t s);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    write_reg(bmlc_pkg::CFG_SHORT_PRESS, s.short_press_ticks);
    write_reg(bmlc_pkg::CFG_LONG_PRESS, s.long_press_ticks);
    write_reg(bmlc_pkg::CFG_FULL_CMP, s.full_compare);
    write_reg(bmlc_pkg::CFG_REDUCED_CMP, s.reduced_compare);
    write_reg(bmlc_pkg::CFG_WAKE_MODE, {6'b0, s.wake_mode_before});
    cfg_valid <= 1'b0;
    settings = s;
    setting_count++;
  endtask

  task automatic hold_then_release(input int held);
    send_tick(1'b0, 1'($urandom_range(1)));
    repeat (held) send_tick(1'b1, 1'($urandom_range(1)));
    send_tick(1'b0, 1'($urandom_range(1)));
  endtask

  // bring the lamp on with a long hold under the current thresholds
  task automatic make_lit();
    send_tick(1'b0, 1'($urandom_range(1)));
    if (!lamp_lit) hold_then_release(int'(settings.long_press_ticks) + 1);
  endtask

  // press episodes around the thresholds, mixed with loose noise ticks
  task automatic run_random(input int n);
    int start;
    int kind;
    int held;
    int hi;
    start = tick_count;
    while (tick_count - start < n) begin
      kind = $urandom_range(9);
      hi = (settings.long_press_ticks < 40) ? int'(settings.long_press_ticks) + 1 : 40;
      if (kind < 2) begin
        repeat ($urandom_range(1, 4))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        if (kind < 5) held = $urandom_range(1, hi);
        else held = int'(settings.long_press_ticks) + 1 + $urandom_range(3);
        repeat (held) send_tick(1'b1, 1'($urandom_range(1)));
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'($urandom_range(1)));
      end
    end
  endtask

  function automatic bmlc_pkg::cfg_t make_cfg(input int sp, input int lp, input int fc,
                                              input int rc, input int wm);
    bmlc_pkg::cfg_t c;
    c.short_press_ticks = 8'(sp);
    c.long_press_ticks  = 8'(lp);
    c.full_compare      = 8'(fc);
    c.reduced_compare   = 8'(rc);
    c.wake_mode_before  = 2'(wm);
    return c;
  endfunction

  initial begin
    settings = make_cfg(bmlc_pkg::SHORT_PRESS_RST, bmlc_pkg::LONG_PRESS_RST,
                        bmlc_pkg::FULL_CMP_RST, bmlc_pkg::REDUCED_CMP_RST,
                        bmlc_pkg::WAKE_MODE_RST);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: all field combinations at reset defaults
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);

    // directed: turn on, walk the whole mode cycle, release while off
    apply_settings(make_cfg(0, 3, 255, 0, bmlc_pkg::MODE_STROBE));
    send_tick(1'b0, 1'b0);              // release while off clears the counter
    repeat (5) send_tick(1'b1, 1'b0);    // on at the 4th, one ignored while waiting
    send_tick(1'b0, 1'b0);
    repeat (3) begin
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);              // single-tick press beats a zero short threshold
    end
    repeat (4) send_tick(1'b1, 1'b1);    // long hold turns the lamp off
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);              // release while off keeps the mode

    // random, slow sender is rare, receiver mostly stalled
    apply_settings(make_cfg(2, 8, $urandom_range(255), $urandom_range(255),
                            bmlc_pkg::MODE_FULL));
    run_random(100);
    apply_settings(make_cfg(255, 5, 0, 255, bmlc_pkg::MODE_REDUCED));
    run_random(40);
    drain();
    run_random(40);

    // random, pacing swapped
    send_idle_pct = 84;
    recv_idle_pct = 38;
    apply_settings(make_cfg(0, 0, $urandom_range(255), $urandom_range(255), 3));
    run_random(60);
    apply_settings(make_cfg($urandom_range(6), $urandom_range(4, 20), $urandom_range(255),
                            $urandom_range(255), $urandom_range(2)));
    run_random(100);

    // back to back, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(make_cfg(5, 12, $urandom_range(255), $urandom_range(255),
                            bmlc_pkg::MODE_REDUCED));
    run_random(100);

    // counter saturation: a 255 long threshold is never reached, release advances
    make_lit();
    apply_settings(make_cfg(254, 255, 1, 254, bmlc_pkg::MODE_STROBE));
    hold_then_release(257);
    // largest reachable long threshold toggles on the saturating tick
    apply_settings(make_cfg(254, 254, 1, 254, bmlc_pkg::MODE_STROBE));
    hold_then_release(256);

    // reset-valued thresholds written back explicitly
    apply_settings(make_cfg(bmlc_pkg::SHORT_PRESS_RST, bmlc_pkg::LONG_PRESS_RST,
                            bmlc_pkg::FULL_CMP_RST, bmlc_pkg::REDUCED_CMP_RST,
                            bmlc_pkg::WAKE_MODE_RST));
    run_random(60);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("Run covered %0d ticks under %0d register settings and three pacing profiles,",
             tick_count, setting_count + 1);
    $display("including a full drain, counter saturation and all mode transitions; %0d checked",
             results_checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
